/* rtl/cgns_pkg.sv */
// ----------------------------------------------------------------------------
// cgns_pkg
// Shared constants, types and controller/datapath interface for the
// cell-list neighbor search block.
// ----------------------------------------------------------------------------
package cgns_pkg;

  localparam int GridDim      = 16;
  localparam int CellBits     = $clog2(GridDim);
  localparam int CellAddrW    = 3 * CellBits;
  localparam int MaxEntries   = 4096;
  localparam int EntAddrW     = $clog2(MaxEntries);
  localparam int LinkW        = EntAddrW + 1;
  localparam int MaxNeighbors = 63;
  localparam int NbrCntW      = $clog2(MaxNeighbors + 1);

  localparam int CoordW   = 24;
  localparam int RadW     = 16;
  localparam int IdW      = 16;
  localparam int KindW    = 8;
  localparam int ReachW   = 20;
  localparam int SqW      = 50;
  localparam int CellCntW = 5;
  localparam int ShiftW   = 4;
  localparam int OpW      = 2;
  localparam int BoundW   = ReachW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegOriginX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCellsX   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCellsY   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCellsZ   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCellShft = 3'd6;

  localparam logic [OpW-1:0] OpClear  = 2'd0;
  localparam logic [OpW-1:0] OpInsert = 2'd1;
  localparam logic [OpW-1:0] OpQuery  = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [RadW-1:0]   radius;
    logic [IdW-1:0]    ident;
    logic [KindW-1:0]  kind;
    logic [ReachW-1:0] box_reach;
    logic [ReachW-1:0] cutoff;
    logic              mode;
  } item_t;

  typedef struct packed {
    logic [LinkW-1:0]  next;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_z;
    logic [RadW-1:0]   radius;
    logic [IdW-1:0]    ident;
    logic [KindW-1:0]  kind;
  } entry_t;

  typedef enum logic [2:0] {
    ResDone,
    ResOutside,
    ResFull,
    ResOvf,
    ResPendMore,
    ResPendLast
  } res_e;

  typedef enum logic [1:0] {
    MulDx,
    MulDy,
    MulDz,
    MulBound
  } mul_e;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_step;
    logic ins_idx;
    logic head_rd;
    logic head_sel_cur;
    logic ins_commit;
    logic box_load;
    logic link_from_head;
    logic link_from_next;
    logic ent_rd;
    logic diff_load;
    logic mul_en;
    mul_e mul_sel;
    logic acc_load;
    logic acc_add;
    logic pend_load;
    logic cur_adv;
    logic push;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ins_outside;
    logic ins_full;
    logic box_empty;
    logic link_ok;
    logic cur_last;
    logic hit_ok;
    logic n_full;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

/* rtl/cgns_ctrl.sv */
// ----------------------------------------------------------------------------
// cgns_ctrl
// Sequencer for clear sweeps, inserts and the cell box / chain walk of a query.
// ----------------------------------------------------------------------------
module cgns_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  input  logic [cgns_pkg::OpW-1:0] op_i,
  output logic                     s_ready_o,
  input  cgns_pkg::status_t        st_i,
  output cgns_pkg::cmd_t           cmd_o
);

  localparam logic [4:0] S_RCLR     = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_CLR      = 5'd2;
  localparam logic [4:0] S_CLR_RSP  = 5'd3;
  localparam logic [4:0] S_INS_IDX  = 5'd4;
  localparam logic [4:0] S_INS_HEAD = 5'd5;
  localparam logic [4:0] S_INS_WR   = 5'd6;
  localparam logic [4:0] S_Q_BOX    = 5'd7;
  localparam logic [4:0] S_Q_CELL   = 5'd8;
  localparam logic [4:0] S_Q_HEAD   = 5'd9;
  localparam logic [4:0] S_Q_LINK   = 5'd10;
  localparam logic [4:0] S_Q_EDATA  = 5'd11;
  localparam logic [4:0] S_Q_M0     = 5'd12;
  localparam logic [4:0] S_Q_M1     = 5'd13;
  localparam logic [4:0] S_Q_M2     = 5'd14;
  localparam logic [4:0] S_Q_M3     = 5'd15;
  localparam logic [4:0] S_Q_CMP    = 5'd16;
  localparam logic [4:0] S_Q_NEXT   = 5'd17;
  localparam logic [4:0] S_Q_END    = 5'd18;
  localparam logic [4:0] S_Q_OVF    = 5'd19;
  localparam logic [4:0] S_Q_OVF2   = 5'd20;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RCLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_RCLR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_i == cgns_pkg::OpInsert) begin
            state_d = S_INS_IDX;
          end else if (op_i == cgns_pkg::OpQuery) begin
            state_d = S_Q_BOX;
          end else begin
            cmd_o.clr_start = 1'b1;
            state_d = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_CLR_RSP;
      end
      S_CLR_RSP: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.res  = cgns_pkg::ResDone;
          state_d    = S_IDLE;
        end
      end
      S_INS_IDX: begin
        cmd_o.ins_idx = 1'b1;
        state_d = S_INS_HEAD;
      end
      S_INS_HEAD: begin
        cmd_o.head_rd = 1'b1;
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          if (st_i.ins_outside) begin
            cmd_o.res = cgns_pkg::ResOutside;
          end else if (st_i.ins_full) begin
            cmd_o.res = cgns_pkg::ResFull;
          end else begin
            cmd_o.res        = cgns_pkg::ResDone;
            cmd_o.ins_commit = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_Q_BOX: begin
        cmd_o.box_load = 1'b1;
        state_d = S_Q_CELL;
      end
      S_Q_CELL: begin
        if (st_i.box_empty) begin
          state_d = S_Q_END;
        end else begin
          cmd_o.head_rd      = 1'b1;
          cmd_o.head_sel_cur = 1'b1;
          state_d = S_Q_HEAD;
        end
      end
      S_Q_HEAD: begin
        cmd_o.link_from_head = 1'b1;
        state_d = S_Q_LINK;
      end
      S_Q_LINK: begin
        if (st_i.link_ok) begin
          cmd_o.ent_rd = 1'b1;
          state_d = S_Q_EDATA;
        end else if (st_i.cur_last) begin
          state_d = S_Q_END;
        end else begin
          cmd_o.cur_adv = 1'b1;
          state_d = S_Q_CELL;
        end
      end
      S_Q_EDATA: begin
        cmd_o.diff_load = 1'b1;
        state_d = S_Q_M0;
      end
      S_Q_M0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cgns_pkg::MulDx;
        state_d = S_Q_M1;
      end
      S_Q_M1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = cgns_pkg::MulDy;
        cmd_o.acc_load = 1'b1;
        state_d = S_Q_M2;
      end
      S_Q_M2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cgns_pkg::MulDz;
        cmd_o.acc_add = 1'b1;
        state_d = S_Q_M3;
      end
      S_Q_M3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cgns_pkg::MulBound;
        cmd_o.acc_add = 1'b1;
        state_d = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (!st_i.hit_ok) begin
          state_d = S_Q_NEXT;
        end else if (st_i.n_full) begin
          state_d = S_Q_OVF;
        end else if (!st_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
          state_d = S_Q_NEXT;
        end else if (st_i.out_free) begin
          // older hit goes out, this one becomes the pending one
          cmd_o.push      = 1'b1;
          cmd_o.res       = cgns_pkg::ResPendMore;
          cmd_o.pend_load = 1'b1;
          state_d = S_Q_NEXT;
        end
      end
      S_Q_NEXT: begin
        cmd_o.link_from_next = 1'b1;
        state_d = S_Q_LINK;
      end
      S_Q_END: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.res  = st_i.pend_valid ? cgns_pkg::ResPendLast : cgns_pkg::ResDone;
          state_d = S_IDLE;
        end
      end
      S_Q_OVF: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.res  = cgns_pkg::ResPendMore;
          state_d = S_Q_OVF2;
        end
      end
      S_Q_OVF2: begin
        if (st_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.res  = cgns_pkg::ResOvf;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/cgns_dpath.sv */
// ----------------------------------------------------------------------------
// cgns_dpath
// Config registers, cell head and entry memories, box and cursor logic,
// shared squaring multiplier, pending hit and the output register.
// ----------------------------------------------------------------------------
module cgns_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cgns_pkg::cmd_t                cmd_i,
  output cgns_pkg::status_t             st_o,
  input  cgns_pkg::item_t               item_i,
  input  logic                          cfg_we_i,
  input  logic [cgns_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cgns_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic                          m_hit_o,
  output logic                          m_outside_o,
  output logic                          m_overflow_o,
  output logic                          m_last_o,
  output logic [cgns_pkg::IdW-1:0]      m_ident_o,
  output logic [cgns_pkg::SqW-1:0]      m_sq_o
);

  localparam int DW = cgns_pkg::CoordW + 1;
  localparam int BW = cgns_pkg::CoordW + 2;
  localparam int CB = cgns_pkg::CellBits;
  localparam int CW = cgns_pkg::CellCntW;
  localparam int PW = 2 * cgns_pkg::CoordW;
  localparam int BoundWLoc = cgns_pkg::BoundW;

  // configuration
  logic [cgns_pkg::CoordW-1:0] org_q [3];
  logic [CW-1:0]               cnt_q [3];
  logic [cgns_pkg::ShiftW-1:0] shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        org_q[a] <= '0;
        cnt_q[a] <= CW'(16);
      end
      shift_q <= cgns_pkg::ShiftW'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgns_pkg::RegOriginX:  org_q[0] <= cfg_data_i;
        cgns_pkg::RegOriginY:  org_q[1] <= cfg_data_i;
        cgns_pkg::RegOriginZ:  org_q[2] <= cfg_data_i;
        cgns_pkg::RegCellsX:   cnt_q[0] <= cfg_data_i[CW-1:0];
        cgns_pkg::RegCellsY:   cnt_q[1] <= cfg_data_i[CW-1:0];
        cgns_pkg::RegCellsZ:   cnt_q[2] <= cfg_data_i[CW-1:0];
        cgns_pkg::RegCellShft: shift_q  <= cfg_data_i[cgns_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // item register
  cgns_pkg::item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= item_i;
  end

  logic [cgns_pkg::CoordW-1:0] pos_a [3];
  assign pos_a[0] = item_q.pos_x;
  assign pos_a[1] = item_q.pos_y;
  assign pos_a[2] = item_q.pos_z;

  // per-axis index arithmetic, truncation toward zero
  logic [CW-1:0] neff_a [3];
  logic [CW-1:0] nm1_a  [3];
  logic [DW-1:0] d_a    [3];
  logic [DW-1:0] dmag_a [3];
  logic [DW-1:0] dq_a   [3];
  logic [BW-1:0] lo_d_a [3];
  logic [BW-1:0] lo_m_a [3];
  logic [BW-1:0] lo_q_a [3];
  logic [BW-1:0] hi_d_a [3];
  logic [BW-1:0] hi_m_a [3];
  logic [BW-1:0] hi_q_a [3];
  logic          ins_out_a [3];
  logic [CB-1:0] ins_idx_a [3];
  logic [CB:0]   lo_v_a [3];
  logic [CB-1:0] hi_v_a [3];
  logic          empty_a [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neff_a[a] = (cnt_q[a] > CW'(cgns_pkg::GridDim)) ? CW'(cgns_pkg::GridDim) : cnt_q[a];
      nm1_a[a]  = neff_a[a] - CW'(1);
      d_a[a]    = {pos_a[a][cgns_pkg::CoordW-1], pos_a[a]}
                - {org_q[a][cgns_pkg::CoordW-1], org_q[a]};
      dmag_a[a] = d_a[a][DW-1] ? (~d_a[a] + DW'(1)) : d_a[a];
      dq_a[a]   = dmag_a[a] >> shift_q;
      ins_out_a[a] = (d_a[a][DW-1] && (dq_a[a] != '0)) || (dq_a[a] >= DW'(neff_a[a]));
      ins_idx_a[a] = dq_a[a][CB-1:0];

      lo_d_a[a] = {d_a[a][DW-1], d_a[a]} - BW'(item_q.box_reach);
      hi_d_a[a] = {d_a[a][DW-1], d_a[a]} + BW'(item_q.box_reach);
      lo_m_a[a] = lo_d_a[a][BW-1] ? (~lo_d_a[a] + BW'(1)) : lo_d_a[a];
      hi_m_a[a] = hi_d_a[a][BW-1] ? (~hi_d_a[a] + BW'(1)) : hi_d_a[a];
      lo_q_a[a] = lo_m_a[a] >> shift_q;
      hi_q_a[a] = hi_m_a[a] >> shift_q;

      if (lo_d_a[a][BW-1]) begin
        lo_v_a[a] = '0;
      end else if (lo_q_a[a] >= BW'(cgns_pkg::GridDim)) begin
        lo_v_a[a] = (CB+1)'(cgns_pkg::GridDim);
      end else begin
        lo_v_a[a] = lo_q_a[a][CB:0];
      end
      hi_v_a[a] = (hi_q_a[a] >= BW'(nm1_a[a])) ? nm1_a[a][CB-1:0] : hi_q_a[a][CB-1:0];
      empty_a[a] = (hi_d_a[a][BW-1] && (hi_q_a[a] != '0)) || (neff_a[a] == '0)
                || (lo_v_a[a] > {1'b0, hi_v_a[a]});
    end
  end

  // insert index
  logic                           ins_outside_q;
  logic [cgns_pkg::CellAddrW-1:0] ins_cell_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_idx) begin
      ins_outside_q <= ins_out_a[0] || ins_out_a[1] || ins_out_a[2];
      ins_cell_q    <= {ins_idx_a[0], ins_idx_a[1], ins_idx_a[2]};
    end
  end

  // query box and cell cursor
  logic [CB-1:0] lo_q [3];
  logic [CB-1:0] hi_q [3];
  logic [CB-1:0] cur_q [3];
  logic          box_empty_q;
  logic          cur_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_load) begin
      box_empty_q <= empty_a[0] || empty_a[1] || empty_a[2];
      for (int a = 0; a < 3; a++) begin
        lo_q[a]  <= lo_v_a[a][CB-1:0];
        hi_q[a]  <= hi_v_a[a];
        cur_q[a] <= lo_v_a[a][CB-1:0];
      end
    end else if (cmd_i.cur_adv) begin
      if (cur_q[2] != hi_q[2]) begin
        cur_q[2] <= cur_q[2] + CB'(1);
      end else begin
        cur_q[2] <= lo_q[2];
        if (cur_q[1] != hi_q[1]) begin
          cur_q[1] <= cur_q[1] + CB'(1);
        end else begin
          cur_q[1] <= lo_q[1];
          cur_q[0] <= cur_q[0] + CB'(1);
        end
      end
    end
  end

  assign cur_last = (cur_q[0] == hi_q[0]) && (cur_q[1] == hi_q[1]) && (cur_q[2] == hi_q[2]);

  // clear sweep counter and entry count
  logic [cgns_pkg::CellAddrW-1:0] clr_cnt_q;
  logic [cgns_pkg::LinkW-1:0]     count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      count_q   <= '0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + cgns_pkg::CellAddrW'(1);
      end
      if (cmd_i.clr_start) begin
        count_q <= '0;
      end else if (cmd_i.ins_commit) begin
        count_q <= count_q + cgns_pkg::LinkW'(1);
      end
    end
  end

  // cell head memory
  logic [cgns_pkg::LinkW-1:0]     head_mem [2**cgns_pkg::CellAddrW];
  logic [cgns_pkg::LinkW-1:0]     head_rd_q;
  logic                           head_we;
  logic [cgns_pkg::CellAddrW-1:0] head_waddr;
  logic [cgns_pkg::LinkW-1:0]     head_wdata;
  logic [cgns_pkg::CellAddrW-1:0] head_raddr;

  assign head_we    = cmd_i.clr_step || cmd_i.ins_commit;
  assign head_waddr = cmd_i.clr_step ? clr_cnt_q : ins_cell_q;
  assign head_wdata = cmd_i.clr_step ? '0 : (count_q + cgns_pkg::LinkW'(1));
  assign head_raddr = cmd_i.head_sel_cur ? {cur_q[0], cur_q[1], cur_q[2]} : ins_cell_q;

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (cmd_i.head_rd) head_rd_q <= head_mem[head_raddr];
  end

  // entry memory
  cgns_pkg::entry_t            ent_mem [cgns_pkg::MaxEntries];
  cgns_pkg::entry_t            ent_rd_q;
  cgns_pkg::entry_t            ent_wr;
  logic [cgns_pkg::LinkW-1:0]  link_q;
  logic [cgns_pkg::LinkW-1:0]  link_dec;

  assign link_dec = link_q - cgns_pkg::LinkW'(1);

  always_comb begin
    ent_wr.next   = head_rd_q;
    ent_wr.pos_x  = item_q.pos_x;
    ent_wr.pos_y  = item_q.pos_y;
    ent_wr.pos_z  = item_q.pos_z;
    ent_wr.radius = item_q.radius;
    ent_wr.ident  = item_q.ident;
    ent_wr.kind   = item_q.kind;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit) ent_mem[count_q[cgns_pkg::EntAddrW-1:0]] <= ent_wr;
    if (cmd_i.ent_rd) ent_rd_q <= ent_mem[link_dec[cgns_pkg::EntAddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_from_head) begin
      link_q <= head_rd_q;
    end else if (cmd_i.link_from_next) begin
      link_q <= ent_rd_q.next;
    end
  end

  // distance terms
  logic [cgns_pkg::CoordW-1:0] ent_pos_a [3];
  logic [DW-1:0]               ed_a [3];
  logic [cgns_pkg::CoordW-1:0] dmag_q [3];
  logic [BoundWLoc-1:0]        bound_q;
  logic                        id_ne_q;
  logic                        kind_ok_q;
  logic [cgns_pkg::IdW-1:0]    cand_id_q;

  assign ent_pos_a[0] = ent_rd_q.pos_x;
  assign ent_pos_a[1] = ent_rd_q.pos_y;
  assign ent_pos_a[2] = ent_rd_q.pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ed_a[a] = {pos_a[a][cgns_pkg::CoordW-1], pos_a[a]}
              - {ent_pos_a[a][cgns_pkg::CoordW-1], ent_pos_a[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_load) begin
      for (int a = 0; a < 3; a++) begin
        dmag_q[a] <= ed_a[a][DW-1] ? cgns_pkg::CoordW'(~ed_a[a] + DW'(1))
                                   : ed_a[a][cgns_pkg::CoordW-1:0];
      end
      bound_q   <= item_q.mode ? BoundWLoc'(item_q.cutoff)
                               : BoundWLoc'(item_q.radius) + BoundWLoc'(item_q.cutoff)
                                 + BoundWLoc'(ent_rd_q.radius);
      id_ne_q   <= (ent_rd_q.ident != item_q.ident);
      kind_ok_q <= !item_q.mode || (ent_rd_q.kind == item_q.kind);
      cand_id_q <= ent_rd_q.ident;
    end
  end

  // shared squaring multiplier and accumulator
  logic [cgns_pkg::CoordW-1:0] mul_a;
  logic [PW-1:0]               prod_q;
  logic [cgns_pkg::SqW-1:0]    acc_q;

  always_comb begin
    case (cmd_i.mul_sel)
      cgns_pkg::MulDx: mul_a = dmag_q[0];
      cgns_pkg::MulDy: mul_a = dmag_q[1];
      cgns_pkg::MulDz: mul_a = dmag_q[2];
      default:         mul_a = cgns_pkg::CoordW'(bound_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_a;
    if (cmd_i.acc_load) begin
      acc_q <= cgns_pkg::SqW'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + cgns_pkg::SqW'(prod_q);
    end
  end

  // pending hit, held until the next hit or the end of the scan decides last
  logic                         pend_valid_q;
  logic [cgns_pkg::IdW-1:0]     pend_id_q;
  logic [cgns_pkg::SqW-1:0]     pend_sq_q;
  logic [cgns_pkg::NbrCntW-1:0] nbr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      nbr_cnt_q    <= '0;
    end else if (cmd_i.box_load) begin
      pend_valid_q <= 1'b0;
      nbr_cnt_q    <= '0;
    end else if (cmd_i.pend_load) begin
      pend_valid_q <= 1'b1;
      nbr_cnt_q    <= nbr_cnt_q + cgns_pkg::NbrCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) begin
      pend_id_q <= cand_id_q;
      pend_sq_q <= acc_q;
    end
  end

  // output register
  logic                      out_valid_q;
  logic                      out_hit_q, out_outside_q, out_ovf_q, out_last_q;
  logic [cgns_pkg::IdW-1:0]  out_id_q;
  logic [cgns_pkg::SqW-1:0]  out_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_hit_q     <= 1'b0;
      out_outside_q <= 1'b0;
      out_ovf_q     <= 1'b0;
      out_last_q    <= 1'b1;
      out_id_q      <= '0;
      out_sq_q      <= '0;
      case (cmd_i.res)
        cgns_pkg::ResOutside: out_outside_q <= 1'b1;
        cgns_pkg::ResFull:    out_ovf_q     <= 1'b1;
        cgns_pkg::ResOvf:     out_ovf_q     <= 1'b1;
        cgns_pkg::ResPendMore: begin
          out_hit_q  <= 1'b1;
          out_last_q <= 1'b0;
          out_id_q   <= pend_id_q;
          out_sq_q   <= pend_sq_q;
        end
        cgns_pkg::ResPendLast: begin
          out_hit_q <= 1'b1;
          out_id_q  <= pend_id_q;
          out_sq_q  <= pend_sq_q;
        end
        default: ;
      endcase
    end
  end

  assign m_valid_o    = out_valid_q;
  assign m_hit_o      = out_hit_q;
  assign m_outside_o  = out_outside_q;
  assign m_overflow_o = out_ovf_q;
  assign m_last_o     = out_last_q;
  assign m_ident_o    = out_id_q;
  assign m_sq_o       = out_sq_q;

  always_comb begin
    st_o.clr_last    = &clr_cnt_q;
    st_o.ins_outside = ins_outside_q;
    st_o.ins_full    = (count_q == cgns_pkg::LinkW'(cgns_pkg::MaxEntries));
    st_o.box_empty   = box_empty_q;
    st_o.link_ok     = (link_q != '0) && (link_q <= count_q);
    st_o.cur_last    = cur_last;
    st_o.hit_ok      = (acc_q < cgns_pkg::SqW'(prod_q)) && id_ne_q && kind_ok_q;
    st_o.n_full      = (nbr_cnt_q == cgns_pkg::NbrCntW'(cgns_pkg::MaxNeighbors));
    st_o.pend_valid  = pend_valid_q;
    st_o.out_free    = !out_valid_q || m_ready_i;
  end

endmodule

/* rtl/cell_grid_neighbor_search.sv */
// ----------------------------------------------------------------------------
// cell_grid_neighbor_search
// 3D cell-list sphere store with insert, clear and neighbor query.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the op (clear, insert, query), tdata the sphere
// and query fields. One transaction is taken at a time; tready is high only
// while the sequencer is idle.
// Output stream: each input gives one or more result transactions, tlast on
// the final one. tuser flags hit, outside and overflow.
// An insert answers once its cell head has been read, a clear after the
// full head sweep. A query sets up its box, then visits each cell of the
// clamped box and walks each chained entry; its pace is set by the
// single shared squaring multiplier (four squares per entry) and the one
// read port of each memory.
// Reset: a sweep zeroes every cell head; no input is taken
// until it ends. Config writes are accepted at any time.
// Stall: one output register holds a result; while the receiver stalls the
// walk pauses at the next result it wants to send.
// ----------------------------------------------------------------------------
module cell_grid_neighbor_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cgns_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cgns_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, pos_z, radius, ident, kind, box_reach, cutoff, mode, zero pad
  input  logic [159:0]                  s_axis_tdata,
  // op
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // neighbor_ident, neighbor_sq_dist, zero pad
  output logic [71:0]                   m_axis_tdata,
  // hit, outside, overflow
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast
);

  cgns_pkg::item_t   item;
  cgns_pkg::cmd_t    cmd;
  cgns_pkg::status_t st;

  logic                     hit, outside, overflow;
  logic [cgns_pkg::IdW-1:0] nbr_id;
  logic [cgns_pkg::SqW-1:0] nbr_sq;

  always_comb begin
    item.pos_x     = s_axis_tdata[23:0];
    item.pos_y     = s_axis_tdata[47:24];
    item.pos_z     = s_axis_tdata[71:48];
    item.radius    = s_axis_tdata[87:72];
    item.ident     = s_axis_tdata[103:88];
    item.kind      = s_axis_tdata[111:104];
    item.box_reach = s_axis_tdata[131:112];
    item.cutoff    = s_axis_tdata[151:132];
    item.mode      = s_axis_tdata[152];
  end

  cgns_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  cgns_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .item_i       (item),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .m_ready_i    (m_axis_tready),
    .m_valid_o    (m_axis_tvalid),
    .m_hit_o      (hit),
    .m_outside_o  (outside),
    .m_overflow_o (overflow),
    .m_last_o     (m_axis_tlast),
    .m_ident_o    (nbr_id),
    .m_sq_o       (nbr_sq)
  );

  assign m_axis_tdata = {6'b0, nbr_sq, nbr_id};
  assign m_axis_tuser = {overflow, outside, hit};

  // a result is only loaded into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> st.out_free)
    else $error("result pushed into a full output register");

  // the chain walk only reads entries that were written since the last clear
  a_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ent_rd |-> st.link_ok)
    else $error("entry read through an invalid link");

  // nothing is stored for a dropped insert
  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_commit |-> (!st.ins_outside && !st.ins_full))
    else $error("insert stored although flagged");

endmodule
